// ===== rtl/core/pct_pkg.sv =====
`default_nettype none

package pct_pkg;

  // Default limits
  localparam int DEF_MAX_WORD_LEN   = 256;
  localparam int DEF_MAX_NEST_LEVEL = 255;

  // Lexer passes per byte (re-dispatch after a token end or escape end)
  localparam int NUM_PASS  = 3;
  // Result queue depth (power of two)
  localparam int OUT_DEPTH = 4;

  // Lexer states
  localparam logic [3:0] LEX_IDLE    = 4'd0;
  localparam logic [3:0] LEX_COMMENT = 4'd1;
  localparam logic [3:0] LEX_NAME    = 4'd2;
  localparam logic [3:0] LEX_LT      = 4'd3;
  localparam logic [3:0] LEX_KEYWORD = 4'd4;
  localparam logic [3:0] LEX_NUMBER  = 4'd5;
  localparam logic [3:0] LEX_HEX     = 4'd6;
  localparam logic [3:0] LEX_STRING  = 4'd7;
  localparam logic [3:0] LEX_GT      = 4'd8;

  // String sub-states
  localparam logic [2:0] SUB_PLAIN  = 3'd0;
  localparam logic [2:0] SUB_ESC    = 3'd1;
  localparam logic [2:0] SUB_OCT1   = 3'd2;
  localparam logic [2:0] SUB_OCT2   = 3'd3;
  localparam logic [2:0] SUB_ESC_CR = 3'd4;

  // Event kinds
  localparam logic [3:0] EV_BYTE        = 4'd0;
  localparam logic [3:0] EV_NAME_END    = 4'd1;
  localparam logic [3:0] EV_NUMBER_END  = 4'd2;
  localparam logic [3:0] EV_KEYWORD_END = 4'd3;
  localparam logic [3:0] EV_STRING_END  = 4'd4;
  localparam logic [3:0] EV_HEX_END     = 4'd5;
  localparam logic [3:0] EV_ARRAY_OPEN  = 4'd6;
  localparam logic [3:0] EV_ARRAY_CLOSE = 4'd7;
  localparam logic [3:0] EV_DICT_OPEN   = 4'd8;
  localparam logic [3:0] EV_DICT_CLOSE  = 4'd9;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Fixed-width part of the lexer state
  typedef struct packed {
    logic [3:0] lex_state;
    logic [2:0] sub_state;
    logic [8:0] esc_value;
  } lex_ctl_t;

  // One event
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] tbyte;
  } res_t;

  // What one lexer pass produces
  typedef struct packed {
    logic emit;
    logic again;
    res_t ev;
  } pass_res_t;

  // Result queue entry
  typedef struct packed {
    res_t ev;
    logic last;
  } out_ent_t;

endpackage

`default_nettype wire

// ===== rtl/core/pct_pass.sv =====
`default_nettype none

// One lexer pass over a byte: next state, optional event, re-dispatch flag.
module pct_pass
  import pct_pkg::*;
#(
  parameter int MAX_WORD_LEN   = DEF_MAX_WORD_LEN,
  parameter int MAX_NEST_LEVEL = DEF_MAX_NEST_LEVEL,
  localparam int WLEN_W = $clog2(MAX_WORD_LEN + 1),
  localparam int NEST_W = $clog2(MAX_NEST_LEVEL + 1)
) (
  input  wire logic [7:0]        data_byte,
  input  var  lex_ctl_t          ctl_i,
  input  wire logic [NEST_W-1:0] nest_i,
  input  wire logic [WLEN_W-1:0] wlen_i,
  output lex_ctl_t               ctl_o,
  output logic [NEST_W-1:0]      nest_o,
  output logic [WLEN_W-1:0]      wlen_o,
  output pass_res_t              res_o
);

  logic       is_ws;
  logic       is_num;
  logic       is_dlm;
  logic       is_word;
  logic       is_oct;
  logic [8:0] esc_shift;

  always_comb begin
    is_ws  = (data_byte == CH_NUL) || (data_byte == CH_TAB) || (data_byte == CH_LF) ||
             (data_byte == CH_FF) || (data_byte == CH_CR) || (data_byte == CH_SPACE);
    is_num = ((data_byte >= CH_ZERO) && (data_byte <= CH_NINE)) || (data_byte == CH_DOT) ||
             (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
    is_dlm = (data_byte == CH_LPAREN) || (data_byte == CH_RPAREN) || (data_byte == CH_LT) ||
             (data_byte == CH_GT) || (data_byte == CH_LBRACK) || (data_byte == CH_RBRACK) ||
             (data_byte == CH_LBRACE) || (data_byte == CH_RBRACE) ||
             (data_byte == CH_SLASH) || (data_byte == CH_PCT);
    is_word   = !is_ws && !is_dlm;  // regular or numeric
    is_oct    = (data_byte >= CH_ZERO) && (data_byte <= CH_SEVEN);
    esc_shift = {ctl_i.esc_value[5:0], data_byte[2:0]};  // (v*8 + d) mod 512
  end

  always_comb begin
    ctl_o        = ctl_i;
    nest_o       = nest_i;
    wlen_o       = wlen_i;
    res_o.emit   = 1'b0;
    res_o.again  = 1'b0;
    res_o.ev     = '{kind: EV_BYTE, tbyte: 8'h00};

    unique case (ctl_i.lex_state) inside
      LEX_COMMENT: begin
        if (data_byte == CH_LF || data_byte == CH_CR) begin
          ctl_o.lex_state = LEX_IDLE;
        end
      end

      LEX_NAME, LEX_KEYWORD, LEX_NUMBER: begin
        if ((ctl_i.lex_state == LEX_NUMBER) ? !is_num : !is_word) begin
          res_o.emit  = 1'b1;
          res_o.again = 1'b1;
          ctl_o.lex_state = LEX_IDLE;
          if (ctl_i.lex_state == LEX_NAME) begin
            res_o.ev.kind = EV_NAME_END;
          end else if (ctl_i.lex_state == LEX_KEYWORD) begin
            res_o.ev.kind = EV_KEYWORD_END;
          end else begin
            res_o.ev.kind = EV_NUMBER_END;
          end
        end else if (wlen_i < WLEN_W'(MAX_WORD_LEN)) begin
          // bytes past the word limit are dropped
          wlen_o         = wlen_i + WLEN_W'(1);
          res_o.emit     = 1'b1;
          res_o.ev.tbyte = data_byte;
        end
      end

      LEX_LT: begin
        if (data_byte == CH_LT) begin
          res_o.emit      = 1'b1;
          res_o.ev.kind   = EV_DICT_OPEN;
          ctl_o.lex_state = LEX_IDLE;
        end else begin
          ctl_o.lex_state = LEX_HEX;
          res_o.again     = 1'b1;
        end
      end

      LEX_HEX: begin
        res_o.emit = 1'b1;
        if (data_byte == CH_GT) begin
          res_o.ev.kind   = EV_HEX_END;
          ctl_o.lex_state = LEX_IDLE;
        end else begin
          res_o.ev.tbyte = data_byte;
        end
      end

      LEX_STRING: begin
        unique case (ctl_i.sub_state) inside
          SUB_ESC: begin
            if (is_oct) begin
              ctl_o.esc_value = {6'd0, data_byte[2:0]};
              ctl_o.sub_state = SUB_OCT1;
            end else begin
              ctl_o.sub_state = SUB_PLAIN;
              res_o.emit      = 1'b1;
              case (data_byte)
                CH_LC_N: res_o.ev.tbyte = CH_LF;
                CH_LC_R: res_o.ev.tbyte = CH_CR;
                CH_LC_T: res_o.ev.tbyte = CH_TAB;
                CH_LC_B: res_o.ev.tbyte = CH_BS;
                CH_LC_F: res_o.ev.tbyte = CH_FF;
                CH_CR: begin
                  res_o.emit      = 1'b0;
                  ctl_o.sub_state = SUB_ESC_CR;
                end
                CH_LF:   res_o.emit = 1'b0;  // line continuation
                default: res_o.ev.tbyte = data_byte;
              endcase
            end
          end

          SUB_OCT1, SUB_OCT2: begin
            res_o.emit = 1'b1;
            if (is_oct) begin
              ctl_o.esc_value = esc_shift;
              if (ctl_i.sub_state == SUB_OCT2) begin
                res_o.ev.tbyte  = esc_shift[7:0];
                ctl_o.sub_state = SUB_PLAIN;
              end else begin
                res_o.emit      = 1'b0;
                ctl_o.sub_state = SUB_OCT2;
              end
            end else begin
              // short escape: emit it, then treat the byte as plain
              res_o.ev.tbyte  = ctl_i.esc_value[7:0];
              ctl_o.sub_state = SUB_PLAIN;
              res_o.again     = 1'b1;
            end
          end

          SUB_ESC_CR: begin
            ctl_o.sub_state = SUB_PLAIN;
            res_o.again     = (data_byte != CH_LF);
          end

          default: begin
            ctl_o.sub_state = SUB_PLAIN;
            if (data_byte == CH_RPAREN) begin
              res_o.emit = 1'b1;
              if (nest_i <= NEST_W'(1)) begin
                res_o.ev.kind   = EV_STRING_END;
                nest_o          = '0;
                ctl_o.lex_state = LEX_IDLE;
              end else begin
                nest_o         = nest_i - NEST_W'(1);
                res_o.ev.tbyte = CH_RPAREN;
              end
            end else if (data_byte == CH_LPAREN) begin
              if (nest_i < NEST_W'(MAX_NEST_LEVEL)) begin
                nest_o = nest_i + NEST_W'(1);
              end
              res_o.emit     = 1'b1;
              res_o.ev.tbyte = CH_LPAREN;
            end else if (data_byte == CH_BSLASH) begin
              ctl_o.sub_state = SUB_ESC;
            end else begin
              res_o.emit     = 1'b1;
              res_o.ev.tbyte = data_byte;
            end
          end
        endcase
      end

      LEX_GT: begin
        ctl_o.lex_state = LEX_IDLE;
        if (data_byte == CH_GT) begin
          res_o.emit    = 1'b1;
          res_o.ev.kind = EV_DICT_CLOSE;
        end else begin
          res_o.again = 1'b1;
        end
      end

      default: begin
        ctl_o.lex_state = LEX_IDLE;
        if (is_word) begin
          ctl_o.lex_state = is_num ? LEX_NUMBER : LEX_KEYWORD;
          wlen_o          = WLEN_W'(1);
          res_o.emit      = 1'b1;
          res_o.ev.tbyte  = data_byte;
        end else if (!is_ws) begin
          case (data_byte)
            CH_SLASH: begin
              ctl_o.lex_state = LEX_NAME;
              wlen_o          = '0;
            end
            CH_LBRACK: begin
              res_o.emit    = 1'b1;
              res_o.ev.kind = EV_ARRAY_OPEN;
            end
            CH_RBRACK: begin
              res_o.emit    = 1'b1;
              res_o.ev.kind = EV_ARRAY_CLOSE;
            end
            CH_LPAREN: begin
              ctl_o.lex_state = LEX_STRING;
              ctl_o.sub_state = SUB_PLAIN;
              nest_o          = NEST_W'(1);
            end
            CH_LT:   ctl_o.lex_state = LEX_LT;
            CH_GT:   ctl_o.lex_state = LEX_GT;
            CH_PCT:  ctl_o.lex_state = LEX_COMMENT;
            default: ;  // stray ')', '{', '}'
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pct_out_queue.sv =====
`default_nettype none

// Small result queue: up to two pushes and one pop per cycle.
module pct_out_queue
  import pct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic [1:0] push_cnt,
  input  var  out_ent_t push_a,
  input  var  out_ent_t push_b,
  input  wire logic     pop,
  output out_ent_t      head,
  output logic          q_valid,
  output logic          q_room2
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  out_ent_t           mem [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push_b;
    end
  end

  assign head    = mem[rd_ptr_r];
  assign q_valid = (cnt_r != '0);
  assign q_room2 = (cnt_r <= CNT_W'(OUT_DEPTH - 2));

endmodule

`default_nettype wire

// ===== rtl/core/pdf_content_tokenizer.sv =====
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-------------------------------------------
//  input   | in_valid | in_stall  | in_data_byte[7:0], in_flush
//  result  | out_valid| out_stall | out_event_kind[3:0], out_token_byte[7:0],
//          |          |           | out_last
//
//  One byte per cycle while in_stall is low. Each input transaction updates the
//  lexer state in the cycle it is accepted and pushes 0, 1 or 2 events into a
//  4-entry queue; the queue drains one result transaction per cycle while
//  out_stall is low.
//  in_stall is high while more than two events are queued.
//  Reset (rst_n low, synchronous) returns the lexer to idle and empties the
//  queue; no clearing pass.
`default_nettype none

module pdf_content_tokenizer
  import pct_pkg::*;
#(
  parameter int MAX_WORD_LEN   = DEF_MAX_WORD_LEN,
  parameter int MAX_NEST_LEVEL = DEF_MAX_NEST_LEVEL
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_flush,
  // events out
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_event_kind,
  output logic [7:0]      out_token_byte,
  output logic            out_last
);

  localparam int WLEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int NEST_W = $clog2(MAX_NEST_LEVEL + 1);

  // Lexer state
  lex_ctl_t          ctl_r, ctl_nxt;
  logic [NEST_W-1:0] nest_r, nest_nxt;
  logic [WLEN_W-1:0] wlen_r, wlen_nxt;

  logic in_acc;
  logic out_acc;
  logic q_room2;

  // Pass chain: a byte that closes a token or an escape is dispatched again.
  // Stage k holds the state seen by pass k.
  lex_ctl_t          ctl_s  [NUM_PASS+1];
  logic [NEST_W-1:0] nest_s [NUM_PASS+1];
  logic [WLEN_W-1:0] wlen_s [NUM_PASS+1];
  lex_ctl_t          p_ctl  [NUM_PASS];
  logic [NEST_W-1:0] p_nest [NUM_PASS];
  logic [WLEN_W-1:0] p_wlen [NUM_PASS];
  pass_res_t         p_res  [NUM_PASS];
  logic              act    [NUM_PASS+1];
  logic              ev_en  [NUM_PASS];

  assign ctl_s[0]  = ctl_r;
  assign nest_s[0] = nest_r;
  assign wlen_s[0] = wlen_r;
  assign act[0]    = 1'b1;

  for (genvar k = 0; k < NUM_PASS; k++) begin : g_pass
    pct_pass #(
      .MAX_WORD_LEN   (MAX_WORD_LEN),
      .MAX_NEST_LEVEL (MAX_NEST_LEVEL)
    ) u_pass (
      .data_byte (in_data_byte),
      .ctl_i     (ctl_s[k]),
      .nest_i    (nest_s[k]),
      .wlen_i    (wlen_s[k]),
      .ctl_o     (p_ctl[k]),
      .nest_o    (p_nest[k]),
      .wlen_o    (p_wlen[k]),
      .res_o     (p_res[k])
    );

    // an inactive pass leaves the state untouched
    assign ctl_s[k+1]  = act[k] ? p_ctl[k]  : ctl_s[k];
    assign nest_s[k+1] = act[k] ? p_nest[k] : nest_s[k];
    assign wlen_s[k+1] = act[k] ? p_wlen[k] : wlen_s[k];
    assign act[k+1]    = act[k] && p_res[k].again;
    assign ev_en[k]    = act[k] && p_res[k].emit;
  end

  // Collect the first two events of the chain, or the flush event.
  logic [1:0] push_cnt;
  out_ent_t   push_a;
  out_ent_t   push_b;
  logic [3:0] flush_kind;
  logic       flush_ev;

  always_comb begin
    flush_ev   = 1'b1;
    flush_kind = EV_NAME_END;
    unique case (ctl_r.lex_state)
      LEX_NAME:    flush_kind = EV_NAME_END;
      LEX_KEYWORD: flush_kind = EV_KEYWORD_END;
      LEX_NUMBER:  flush_kind = EV_NUMBER_END;
      LEX_HEX:     flush_kind = EV_HEX_END;
      LEX_STRING:  flush_kind = EV_STRING_END;
      default:     flush_ev   = 1'b0;
    endcase
  end

  always_comb begin
    push_a   = '{ev: p_res[2].ev, last: 1'b1};
    push_b   = '{ev: p_res[2].ev, last: 1'b1};
    push_cnt = 2'd0;

    if (in_flush) begin
      push_a.ev = '{kind: flush_kind, tbyte: 8'h00};
      push_cnt  = flush_ev ? 2'd1 : 2'd0;
      ctl_nxt   = '{lex_state: LEX_IDLE, sub_state: SUB_PLAIN, esc_value: 9'd0};
      nest_nxt  = '0;
      wlen_nxt  = '0;
    end else begin
      ctl_nxt  = ctl_s[NUM_PASS];
      nest_nxt = nest_s[NUM_PASS];
      wlen_nxt = wlen_s[NUM_PASS];

      // first event
      if (ev_en[0]) begin
        push_a.ev = p_res[0].ev;
      end else if (ev_en[1]) begin
        push_a.ev = p_res[1].ev;
      end
      // second event
      if (ev_en[0] && ev_en[1]) begin
        push_b.ev = p_res[1].ev;
      end

      push_cnt = 2'd0;
      if (ev_en[0] || ev_en[1] || ev_en[2]) begin
        push_cnt = 2'd1;
      end
      if ((ev_en[0] && (ev_en[1] || ev_en[2])) || (ev_en[1] && ev_en[2])) begin
        push_cnt = 2'd2;
      end
      // last marks only the final event of this byte
      push_a.last = (push_cnt != 2'd2);
    end

    if (!in_acc) begin
      push_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '{lex_state: LEX_IDLE, sub_state: SUB_PLAIN, esc_value: 9'd0};
      nest_r <= '0;
      wlen_r <= '0;
    end else if (in_acc) begin
      ctl_r  <= ctl_nxt;
      nest_r <= nest_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  // Result queue parts the input from a stalled output.
  out_ent_t head;

  pct_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (out_acc),
    .head     (head),
    .q_valid  (out_valid),
    .q_room2  (q_room2)
  );

  assign in_stall       = !q_room2;
  assign in_acc         = in_valid && !in_stall;
  assign out_acc        = out_valid && !out_stall;
  assign out_event_kind = head.ev.kind;
  assign out_token_byte = head.ev.tbyte;
  assign out_last       = head.last;

  // Assertions

  // flush always lands in idle with no open string
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_flush |=> (ctl_r.lex_state == LEX_IDLE) && (nest_r == '0))
    else $error("flush did not return lexer to idle");

  // nesting depth is nonzero exactly inside a literal string
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.lex_state == LEX_STRING) == (nest_r != '0))
    else $error("nest level out of step with string state");

  // escape sub-states exist only inside a literal string
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.sub_state != SUB_PLAIN) |-> (ctl_r.lex_state == LEX_STRING))
    else $error("string sub-state active outside a string");

  // no state change without an accepted byte
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(ctl_r) && $stable(nest_r) && $stable(wlen_r))
    else $error("lexer state moved without an input transaction");

endmodule

`default_nettype wire
